// ----- design/world_to_screen_projection_macros.svh -----
// ----------------------------------------------------------------------------
// world_to_screen_projection_macros
// Assertion macros for the projection pipeline.
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("projection assertion failed");
`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("projection assertion failed");
`else
`define WSP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants of the world to screen projection.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int CFG_W    = 64;
  localparam int COEF_W   = 32;
  localparam int DIM_W    = 16;
  localparam int IDX_W    = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_X_XY     = 3'd0,
    REG_ROW_X_ZW     = 3'd1,
    REG_ROW_Y_XY     = 3'd2,
    REG_ROW_Y_ZW     = 3'd3,
    REG_ROW_DEPTH_XY = 3'd4,
    REG_ROW_DEPTH_ZW = 3'd5,
    REG_DISPLAY_SIZE = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic vis;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

// ----- design/wsp_sdiv.sv -----
// ----------------------------------------------------------------------------
// wsp_sdiv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module wsp_sdiv
  import wsp_pkg::*;
#(
  parameter int NW = 81,
  parameter int DW = 50
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_r [0:NW-1];
  logic [NW-1:0] nq_r  [0:NW-1];
  logic [DW-1:0] den_r [0:NW-1];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign trial = {rem_in, nq_in[NW-1]} - {1'b0, den_in};
    assign ge    = ~trial[DW];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? trial[DW-1:0] : {rem_in[DW-2:0], nq_in[NW-1]};
        nq_r[k]  <= {nq_in[NW-2:0], ge};
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = nq_r[NW-1];

endmodule

// ----- design/world_to_screen_projection.sv -----
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Perspective projection of world points to saturated screen pixels.
// ----------------------------------------------------------------------------
// One point enters per cycle while the output is not held. Each point passes
// through four stages for input, products, dot sums and scaling, then one
// stage per quotient bit in the divider (COORD_WIDTH + 49), then the output
// register. A held output stalls the whole pipeline.
module world_to_screen_projection
  import wsp_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [IDX_W-1:0]              cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_screen_x,
  output logic signed [COORD_WIDTH-1:0] out_screen_y,
  output logic                          out_visible
);

`include "world_to_screen_projection_macros.svh"

  localparam int PW   = COEF_W + COORD_WIDTH;
  localparam int SW   = PW + 2;
  localparam int DW   = SW - FRAC_BITS;
  localparam int NW   = DW + DIM_W + FRAC_BITS - 1;
  localparam int OW   = NW + 3;
  localparam int NEAR = (1 << FRAC_BITS) / 10;
  localparam logic signed [DW-1:0] NEAR_LIM = DW'(NEAR);
  localparam logic signed [OW-1:0] SMAX = (OW'(1) <<< (COORD_WIDTH-1)) - OW'(1);
  localparam logic signed [OW-1:0] SMIN = -(OW'(1) <<< (COORD_WIDTH-1));
  localparam logic signed [OW-1:0] HALF = OW'(1) <<< (FRAC_BITS-1);

  logic [CFG_W-1:0] cfg_r [0:5];
  logic [2*DIM_W-1:0] disp_r;
  logic [DIM_W-1:0] w_dim, h_dim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) cfg_r[i] <= '0;
      disp_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW_X_XY, REG_ROW_X_ZW, REG_ROW_Y_XY, REG_ROW_Y_ZW,
        REG_ROW_DEPTH_XY, REG_ROW_DEPTH_ZW: cfg_r[cfg_index] <= cfg_data;
        REG_DISPLAY_SIZE: disp_r <= cfg_data[2*DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_dim = disp_r[DIM_W-1:0];
  assign h_dim = disp_r[2*DIM_W-1:DIM_W];

  // coef[row][0..2] for x, y, z; coef[row][3] is the offset
  logic signed [COEF_W-1:0] coef [0:2][0:3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = cfg_r[2*r][COEF_W-1:0];
      coef[r][1] = cfg_r[2*r][CFG_W-1:COEF_W];
      coef[r][2] = cfg_r[2*r+1][COEF_W-1:0];
      coef[r][3] = cfg_r[2*r+1][CFG_W-1:COEF_W];
    end
  end

  logic advance;
  assign advance  = ~(out_valid && out_stall);
  assign in_stall = ~advance;

  // stage 0: input register
  logic                          v0_r;
  logic signed [COORD_WIDTH-1:0] p0_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (advance) v0_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      p0_r[0] <= in_pos_x;
      p0_r[1] <= in_pos_y;
      p0_r[2] <= in_pos_z;
    end
  end

  // stage 1: products
  logic                 v1_r;
  logic signed [PW-1:0] prod_r [0:2][0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (advance) v1_r <= v0_r;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          prod_r[r][c] <= PW'(coef[r][c]) * PW'(p0_r[c]);
    end
  end

  // stage 2: dot sums, near test, magnitudes
  logic signed [SW-1:0] sum [0:2];
  logic signed [DW-1:0] dotv [0:2];
  logic                 vis_nxt;
  logic [DW-1:0]        magx_nxt, magy_nxt;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r]  = SW'(prod_r[r][0]) + SW'(prod_r[r][1]) + SW'(prod_r[r][2])
              + (SW'(coef[r][3]) <<< FRAC_BITS);
      dotv[r] = sum[r][SW-1:FRAC_BITS];
    end
    vis_nxt  = dotv[2] > NEAR_LIM;
    magx_nxt = dotv[0][DW-1] ? DW'(-dotv[0]) : DW'(dotv[0]);
    magy_nxt = dotv[1][DW-1] ? DW'(-dotv[1]) : DW'(dotv[1]);
  end

  ctl_t          ctl2_r;
  logic [DW-1:0] d2_r, magx2_r, magy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ctl2_r <= '0;
    else if (advance) ctl2_r <= '{valid: v1_r, vis: vis_nxt,
                                  neg_x: dotv[0][DW-1], neg_y: dotv[1][DW-1]};
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      d2_r    <= dotv[2];
      magx2_r <= magx_nxt;
      magy2_r <= magy_nxt;
    end
  end

  // stage 3: scaled numerators
  ctl_t                      ctl3_r;
  logic [NW-1:0]             numx3_r, numy3_r;
  logic [DW-1:0]             d3_r;
  logic [DW+DIM_W-1:0]       sclx, scly;

  assign sclx = (DW+DIM_W)'(magx2_r) * (DW+DIM_W)'(w_dim);
  assign scly = (DW+DIM_W)'(magy2_r) * (DW+DIM_W)'(h_dim);

  always_ff @(posedge clk) begin
    if (!rst_n) ctl3_r <= '0;
    else if (advance) ctl3_r <= ctl2_r;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      numx3_r <= {sclx, {(FRAC_BITS-1){1'b0}}};
      numy3_r <= {scly, {(FRAC_BITS-1){1'b0}}};
      d3_r    <= d2_r;
    end
  end

  // divider stages
  logic [NW-1:0] qx, qy;
  ctl_t          ctl_r [0:NW-1];

  wsp_sdiv #(.NW(NW), .DW(DW)) u_div_x (
    .clk(clk), .en(advance), .num(numx3_r), .den(d3_r), .quo(qx)
  );
  wsp_sdiv #(.NW(NW), .DW(DW)) u_div_y (
    .clk(clk), .en(advance), .num(numy3_r), .den(d3_r), .quo(qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NW; k++) ctl_r[k] <= '0;
    end else if (advance) begin
      ctl_r[0] <= ctl3_r;
      for (int k = 1; k < NW; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  // output stage: sign, centre offset, saturation, zero for hidden points
  ctl_t                 ctlq;
  logic signed [OW-1:0] sqx, sqy, sx, sy;
  logic signed [COORD_WIDTH-1:0] satx, saty;

  assign ctlq = ctl_r[NW-1];

  always_comb begin
    sqx = ctlq.neg_x ? -$signed(OW'(qx)) : $signed(OW'(qx));
    sqy = ctlq.neg_y ? -$signed(OW'(qy)) : $signed(OW'(qy));
    sx  = sqx + (OW'(w_dim) <<< (FRAC_BITS-1)) + HALF;
    sy  = (OW'(h_dim) <<< (FRAC_BITS-1)) - sqy - HALF;
    if (sx > SMAX)      satx = SMAX[COORD_WIDTH-1:0];
    else if (sx < SMIN) satx = SMIN[COORD_WIDTH-1:0];
    else                satx = sx[COORD_WIDTH-1:0];
    if (sy > SMAX)      saty = SMAX[COORD_WIDTH-1:0];
    else if (sy < SMIN) saty = SMIN[COORD_WIDTH-1:0];
    else                saty = sy[COORD_WIDTH-1:0];
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (advance) out_valid_r <= ctlq.valid;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      out_visible  <= ctlq.vis;
      out_screen_x <= ctlq.vis ? satx : '0;
      out_screen_y <= ctlq.vis ? saty : '0;
    end
  end

  assign out_valid = out_valid_r;

  `WSP_ASSERT_IMP(a_hidden_zero, clk, rst_n, out_valid && !out_visible,
    out_screen_x == '0 && out_screen_y == '0)
  `WSP_ASSERT_IMP(a_stall_only_when_held, clk, rst_n, in_stall, out_valid)
  `WSP_ASSERT_NEXT(a_held_result_stays, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_screen_x) && $stable(out_visible))

endmodule

// ----- dv/world_to_screen_projection_tb.sv -----
// ----------------------------------------------------------------------------
// world_to_screen_projection_tb
// Self-checking bench for the world to screen projection. Points are driven
// through a valid/stall handshake under several idle and stall mixes. Every
// result is checked in order against fixed values or a bit-exact projection
// model in the bench, across a range of view matrices and display sizes.
// ----------------------------------------------------------------------------
module world_to_screen_projection_tb
  import wsp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int CW = 32;
  localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic signed [127:0] NEAR_LIM = 128'sd6553;
  localparam logic signed [127:0] ONE = 128'sd65536;

  typedef struct {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic vis;
  } screen_pt_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    bit known;
    screen_pt_t pt;
  } point_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_pos_x = '0;
  logic signed [CW-1:0] in_pos_y = '0;
  logic signed [CW-1:0] in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] out_screen_x;
  logic signed [CW-1:0] out_screen_y;
  logic out_visible;

  logic [63:0] view_regs [7];
  screen_pt_t pending_pts[$];
  int n_errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  world_to_screen_projection u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_screen_x(out_screen_x), .out_screen_y(out_screen_y),
    .out_visible(out_visible)
  );

  function automatic logic signed [127:0] view_dot(logic [63:0] rxy, logic [63:0] rzw,
                                                   logic signed [CW-1:0] x,
                                                   logic signed [CW-1:0] y,
                                                   logic signed [CW-1:0] z);
    logic signed [127:0] cx, cy, cz, off, px, py, pz, s;
    cx = signed'(rxy[31:0]);
    cy = signed'(rxy[63:32]);
    cz = signed'(rzw[31:0]);
    off = signed'(rzw[63:32]);
    px = x;
    py = y;
    pz = z;
    s = cx * px + cy * py + cz * pz + off * ONE;
    return s >>> FRAC;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[CW-1:0];
  endfunction

  function automatic logic signed [127:0] scaled_quot(logic signed [127:0] num,
                                                      logic signed [127:0] scale,
                                                      logic signed [127:0] den);
    logic signed [127:0] mag, q;
    mag = (num < 0) ? -num : num;
    q = ((mag * scale) <<< (FRAC - 1)) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic screen_pt_t project_point(logic signed [CW-1:0] x,
                                               logic signed [CW-1:0] y,
                                               logic signed [CW-1:0] z);
    screen_pt_t r;
    logic signed [127:0] vx, vy, vd, w, h;
    vx = view_dot(view_regs[REG_ROW_X_XY], view_regs[REG_ROW_X_ZW], x, y, z);
    vy = view_dot(view_regs[REG_ROW_Y_XY], view_regs[REG_ROW_Y_ZW], x, y, z);
    vd = view_dot(view_regs[REG_ROW_DEPTH_XY], view_regs[REG_ROW_DEPTH_ZW], x, y, z);
    w = {112'd0, view_regs[REG_DISPLAY_SIZE][15:0]};
    h = {112'd0, view_regs[REG_DISPLAY_SIZE][31:16]};
    if (vd <= NEAR_LIM) begin
      r.sx = '0;
      r.sy = '0;
      r.vis = 1'b0;
    end else begin
      r.sx = clamp_coord(scaled_quot(vx, w, vd) + (w <<< (FRAC - 1)) + 128'sd32768);
      r.sy = clamp_coord((h <<< (FRAC - 1)) - scaled_quot(vy, h, vd) - 128'sd32768);
      r.vis = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    screen_pt_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("world_to_screen_projection test failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_pts.size() == 0) begin
          report_mismatch("unexpected result", out_screen_x, '0);
        end else begin
          e = pending_pts.pop_front();
          if (out_screen_x !== e.sx) report_mismatch("screen_x", out_screen_x, e.sx);
          if (out_screen_y !== e.sy) report_mismatch("screen_y", out_screen_y, e.sy);
          if (out_visible !== e.vis) report_mismatch("visible", out_visible, e.vis);
        end
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // called at a falling edge; returns at a falling edge
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx < REG_DISPLAY_SIZE) view_regs[idx] = val;
    else if (idx == REG_DISPLAY_SIZE) view_regs[idx] = {32'd0, val[31:0]};
    @(negedge clk);
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic signed [CW-1:0] z, bit known, screen_pt_t pt);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    do @(posedge clk); while (in_stall);
    pending_pts.push_back(known ? pt : project_point(x, y, z));
    @(negedge clk);
  endtask

  function automatic logic [31:0] coef_word(int mode);
    case (mode)
      0: return 32'h0001_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return $urandom();
      default: return 32'($signed($urandom_range(262144)) - 131072);
    endcase
  endfunction

  task automatic load_view(int mode, logic [31:0] disp);
    logic [31:0] dc;
    for (int r = 0; r < 6; r++) begin
      write_reg(r[IDX_W-1:0], {coef_word(mode), coef_word(mode)});
    end
    if (mode >= 3) begin
      // keep depth mostly positive so most points come out visible
      dc = 32'($urandom_range(131072) + 16384);
      write_reg(REG_ROW_DEPTH_ZW, {dc, coef_word(4) >>> 4});
    end
    write_reg(REG_DISPLAY_SIZE, {$urandom(), disp});
    write_reg(IDX_UNUSED, {$urandom(), $urandom()});
  endtask

  task automatic random_points(int count);
    logic signed [CW-1:0] x, y, z;
    screen_pt_t none;
    none = '{default: '0};
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7) begin
        x = 32'($signed($urandom_range(2097152)) - 1048576);
        y = 32'($signed($urandom_range(2097152)) - 1048576);
        z = 32'($signed($urandom_range(2097152)) - 1048576);
      end else begin
        x = $urandom();
        y = $urandom();
        z = $urandom();
      end
      send_point(x, y, z, 1'b0, none);
    end
  endtask

  point_row_t reset_rows[] = '{
    '{32'sh0, 32'sh0, 32'sh0, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
    '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
    '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
    '{32'shffffffff, 32'sh00010000, 32'sh7fffffff, 1'b1, '{32'sh0, 32'sh0, 1'b0}}
  };

  // identity view: depth equals z
  point_row_t view_rows[] = '{
    '{32'sh0, 32'sh0, 32'sh1999, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
    '{32'sh0, 32'sh0, 32'sh199a, 1'b0, '{32'sh0, 32'sh0, 1'b0}},
    '{32'sh10000, 32'sh10000, 32'sh0, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
    '{32'sh10000, 32'sh10000, -32'sh10000, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
    '{32'sh0, 32'sh0, 32'sh10000, 1'b0, '{32'sh0, 32'sh0, 1'b0}},
    '{32'sh10000, -32'sh10000, 32'sh10000, 1'b0, '{32'sh0, 32'sh0, 1'b0}},
    '{32'sh7fffffff, 32'sh80000000, 32'sh199a, 1'b0, '{32'sh0, 32'sh0, 1'b0}},
    '{32'sh80000000, 32'sh7fffffff, 32'sh199a, 1'b0, '{32'sh0, 32'sh0, 1'b0}},
    '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, '{32'sh0, 32'sh0, 1'b0}},
    '{-32'sh8000, 32'sh8000, 32'sh20000, 1'b0, '{32'sh0, 32'sh0, 1'b0}},
    '{32'sh12345, -32'sh6789a, 32'sh3456, 1'b0, '{32'sh0, 32'sh0, 1'b0}}
  };

  initial begin
    int idles[4] = '{0, 52, 0, 28};
    int stalls[4] = '{0, 0, 52, 28};
    for (int i = 0; i < 7; i++) view_regs[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (reset_rows[i]) begin
      send_point(reset_rows[i].x, reset_rows[i].y, reset_rows[i].z,
                 reset_rows[i].known, reset_rows[i].pt);
    end
    drain_pipe();
    load_view(0, {16'd1080, 16'd1920});
    write_reg(REG_ROW_X_XY, {32'h0, 32'h0001_0000});
    write_reg(REG_ROW_X_ZW, 64'h0);
    write_reg(REG_ROW_Y_XY, {32'h0001_0000, 32'h0});
    write_reg(REG_ROW_Y_ZW, 64'h0);
    write_reg(REG_ROW_DEPTH_XY, 64'h0);
    write_reg(REG_ROW_DEPTH_ZW, {32'h0, 32'h0001_0000});
    foreach (view_rows[i]) begin
      send_point(view_rows[i].x, view_rows[i].y, view_rows[i].z,
                 view_rows[i].known, view_rows[i].pt);
    end
    drain_pipe();
    write_reg(REG_DISPLAY_SIZE, 64'hffff_ffff_0000_0000);
    foreach (view_rows[i]) begin
      send_point(view_rows[i].x, view_rows[i].y, view_rows[i].z, 1'b0, view_rows[i].pt);
    end
    drain_pipe();
    write_reg(REG_DISPLAY_SIZE, 64'h0000_0000_ffff_ffff);
    random_points(60);

    for (int p = 0; p < 4; p++) begin
      idle_pct = idles[p];
      stall_pct = stalls[p];
      for (int s = 0; s < 4; s++) begin
        drain_pipe();
        case (s)
          0: load_view(4, {16'd1080, 16'd1920});
          1: load_view(3, $urandom());
          2: load_view(4, {16'($urandom_range(4096)), 16'($urandom_range(4096))});
          default: load_view(1 + (p % 2), 32'hffff_ffff);
        endcase
        random_points(s == 3 ? 40 : 140);
      end
    end
    idle_pct = 0;
    stall_pct = 0;
    in_valid <= 1'b0;

    while (pending_pts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0) $display("world_to_screen_projection test passed");
    else $display("world_to_screen_projection test failed");
    $finish;
  end

endmodule
